/* hw/rtl/pnq_pkg.sv */
// Package for the per-node FCFS queue manager: sizes, codes and the structs
// passed between the engine, the RAMs and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pnq_pkg;

    localparam int NUM_NODES    = 16;
    localparam int POOL_ENTRIES = 256;

    localparam int IDX_W   = $clog2(POOL_ENTRIES);
    localparam int PTR_W   = IDX_W + 1;
    localparam int NODE_W  = 4;
    localparam int NIDX_W  = $clog2(NUM_NODES);
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TRAV_W  = 16;
    localparam int PROC_W  = 22;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = NODE_W + PROC_W + TRAV_W + STAMP_W;

    localparam logic [PTR_W-1:0] PTR_EMPTY = PTR_W'(POOL_ENTRIES);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] NODE_CAP  = CFG_W'(NUM_NODES);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_SIZE    = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic               re;
        logic [IDX_W-1:0]   raddr;
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
    } entry_req_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [PTR_W-1:0] wdata;
    } link_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [NODE_W-1:0]  served_node;
        logic [TRAV_W-1:0]  out_traveler;
        logic [PROC_W-1:0]  out_process;
        logic [NODE_W-1:0]  out_next_node;
        logic [STAMP_W-1:0] arrival_number;
        logic [CNT_W-1:0]   queue_length;
        logic               has_waiting;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/pnq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pnq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pnq_engine.sv */
// Command sequencer of the queue manager: node tables, free list, fresh
// pointer and arrival counter. Depends on pnq_pkg; drives two pnq_ram instances.
`timescale 1ns / 1ps
`default_nettype none

module pnq_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pnq_pkg::CMD_W-1:0]   command,
    input  wire logic [pnq_pkg::NODE_W-1:0]  node_id,
    input  wire logic [pnq_pkg::TRAV_W-1:0]  traveler,
    input  wire logic [pnq_pkg::PROC_W-1:0]  process_id,
    input  wire logic [pnq_pkg::NODE_W-1:0]  dest_node,
    input  wire logic [pnq_pkg::CFG_W-1:0]   node_limit,
    output      logic                        busy,
    output pnq_pkg::entry_req_t              entry_req,
    input  wire logic [pnq_pkg::ENTRY_W-1:0] entry_rdata,
    output pnq_pkg::link_req_t               link_req,
    input  wire logic [pnq_pkg::PTR_W-1:0]   link_rdata,
    output      logic                        result_valid,
    output pnq_pkg::result_t                 result
);

    pnq_pkg::fsm_t state_reg, state_next;

    logic [pnq_pkg::CMD_W-1:0]  cmd_reg;
    logic [pnq_pkg::NODE_W-1:0] node_reg;
    logic [pnq_pkg::TRAV_W-1:0] trav_reg;
    logic [pnq_pkg::PROC_W-1:0] proc_reg;
    logic [pnq_pkg::NODE_W-1:0] dest_reg;

    logic [pnq_pkg::IDX_W-1:0] heads_reg  [pnq_pkg::NUM_NODES];
    logic [pnq_pkg::IDX_W-1:0] tails_reg  [pnq_pkg::NUM_NODES];
    logic [pnq_pkg::CNT_W-1:0] counts_reg [pnq_pkg::NUM_NODES];

    logic [pnq_pkg::PTR_W-1:0]   free_head_reg, free_head_next;
    logic [pnq_pkg::PTR_W-1:0]   fresh_reg, fresh_next;
    logic [pnq_pkg::STAMP_W-1:0] arrival_reg, arrival_next;
    logic                        result_valid_reg, result_valid_next;
    pnq_pkg::result_t            result_reg, result_next;

    logic                       head_we, tail_we, count_we;
    logic [pnq_pkg::IDX_W-1:0]  head_next, tail_next;
    logic [pnq_pkg::CNT_W-1:0]  count_next;

    logic                       accept;
    logic                       exec;
    logic [pnq_pkg::NIDX_W-1:0] node_idx;
    logic [pnq_pkg::CNT_W-1:0]  cur_count;
    logic [pnq_pkg::IDX_W-1:0]  cur_head;
    logic                       node_ok;
    logic                       alloc_ok;
    logic [pnq_pkg::IDX_W-1:0]  alloc_idx;

    assign accept   = start && (state_reg == pnq_pkg::FSM_IDLE);
    assign exec     = (state_reg == pnq_pkg::FSM_EXEC);
    assign node_idx = node_reg[pnq_pkg::NIDX_W-1:0];
    assign cur_count = counts_reg[node_idx];
    assign cur_head  = heads_reg[node_idx];
    assign node_ok   = {1'b0, node_reg} < node_limit;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pnq_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = pnq_pkg::FSM_EXEC;
                end
            end
            pnq_pkg::FSM_EXEC:
            begin
                state_next = pnq_pkg::FSM_IDLE;
            end
        endcase
    end

    assign busy = exec;

    // Allocation: the free list first, then entries never used.
    always_comb
    begin
        alloc_ok  = 1'b0;
        alloc_idx = free_head_reg[pnq_pkg::IDX_W-1:0];
        if (!free_head_reg[pnq_pkg::IDX_W])
        begin
            alloc_ok = 1'b1;
        end
        else if (!fresh_reg[pnq_pkg::IDX_W])
        begin
            alloc_ok  = 1'b1;
            alloc_idx = fresh_reg[pnq_pkg::IDX_W-1:0];
        end
    end

    // Reads are issued at accept so the data are ready in the execute cycle.
    always_comb
    begin
        entry_req    = '0;
        link_req     = '0;
        entry_req.re = accept;
        entry_req.raddr = heads_reg[node_id[pnq_pkg::NIDX_W-1:0]];
        link_req.re  = accept;
        if (pnq_pkg::cmd_t'(command) == pnq_pkg::CMD_ENQUEUE)
        begin
            link_req.raddr = free_head_reg[pnq_pkg::IDX_W-1:0];
        end
        else
        begin
            link_req.raddr = heads_reg[node_id[pnq_pkg::NIDX_W-1:0]];
        end

        free_head_next    = free_head_reg;
        fresh_next        = fresh_reg;
        arrival_next      = arrival_reg;
        head_we           = 1'b0;
        tail_we           = 1'b0;
        count_we          = 1'b0;
        head_next         = alloc_idx;
        tail_next         = alloc_idx;
        count_next        = cur_count;
        result_valid_next = exec;
        result_next       = '0;

        if (exec)
        begin
            if (!node_ok)
            begin
                result_next.status = pnq_pkg::STAT_INVALID;
            end
            else
            begin
                unique case (pnq_pkg::cmd_t'(cmd_reg))
                    pnq_pkg::CMD_ENQUEUE:
                    begin
                        if (alloc_ok)
                        begin
                            if (!free_head_reg[pnq_pkg::IDX_W])
                            begin
                                free_head_next = link_rdata;
                            end
                            else
                            begin
                                fresh_next = fresh_reg + 1'b1;
                            end
                            entry_req.we    = 1'b1;
                            entry_req.waddr = alloc_idx;
                            entry_req.wdata = {dest_reg, proc_reg, trav_reg, arrival_reg};
                            if (cur_count != '0)
                            begin
                                link_req.we    = 1'b1;
                                link_req.waddr = tails_reg[node_idx];
                                link_req.wdata = {1'b0, alloc_idx};
                            end
                            else
                            begin
                                head_we = 1'b1;
                            end
                            tail_we    = 1'b1;
                            count_we   = 1'b1;
                            count_next = cur_count + 1'b1;
                            arrival_next = arrival_reg + 1'b1;
                            result_next.status         = pnq_pkg::STAT_DONE;
                            result_next.arrival_number = arrival_reg;
                            result_next.queue_length   = count_next;
                            result_next.has_waiting    = 1'b1;
                        end
                        else
                        begin
                            result_next.status       = pnq_pkg::STAT_FULL;
                            result_next.queue_length = cur_count;
                            result_next.has_waiting  = (cur_count != '0);
                        end
                    end
                    pnq_pkg::CMD_DEQUEUE:
                    begin
                        if (cur_count == '0)
                        begin
                            result_next.status = pnq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            head_we    = 1'b1;
                            head_next  = link_rdata[pnq_pkg::IDX_W-1:0];
                            count_we   = 1'b1;
                            count_next = cur_count - 1'b1;
                            link_req.we    = 1'b1;
                            link_req.waddr = cur_head;
                            link_req.wdata = free_head_reg;
                            free_head_next = {1'b0, cur_head};
                            {result_next.out_next_node, result_next.out_process,
                             result_next.out_traveler,
                             result_next.arrival_number} = entry_rdata;
                            result_next.status       = pnq_pkg::STAT_DONE;
                            result_next.served_node  = node_reg;
                            result_next.queue_length = count_next;
                            result_next.has_waiting  = (count_next != '0);
                        end
                    end
                    default:
                    begin
                        result_next.status       = pnq_pkg::STAT_DONE;
                        result_next.queue_length = cur_count;
                        result_next.has_waiting  = (cur_count != '0);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pnq_pkg::FSM_IDLE;
            free_head_reg    <= pnq_pkg::PTR_EMPTY;
            fresh_reg        <= '0;
            arrival_reg      <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < pnq_pkg::NUM_NODES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            free_head_reg    <= free_head_next;
            fresh_reg        <= fresh_next;
            arrival_reg      <= arrival_next;
            result_valid_reg <= result_valid_next;
            if (count_we)
            begin
                counts_reg[node_idx] <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            node_reg <= node_id;
            trav_reg <= traveler;
            proc_reg <= process_id;
            dest_reg <= dest_node;
        end
        if (head_we)
        begin
            heads_reg[node_idx] <= head_next;
        end
        if (tail_we)
        begin
            tails_reg[node_idx] <= tail_next;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* hw/rtl/per_node_fcfs_queue_manager_top.sv */
// Top level of the per-node FCFS queue manager: configuration register, the
// entry and link RAMs, and the command engine. Depends on pnq_pkg, pnq_ram, pnq_engine.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one first-come-first-served queue for each of sixteen nodes,
// all sharing a pool of 256 request entries. A command is taken when start is
// high and busy is low; its single result is driven on the result ports in the
// cycle after the execute cycle, for exactly one cycle, marked by result_valid,
// and must be captured at the second rising edge after the command was taken,
// because the receiver cannot stall the block. For every command, the cycle in
// which it is taken reads the link RAM (the free-list successor for an enqueue,
// the head's successor for a dequeue) and the entry RAM, and the execute cycle
// uses that read data to update the node tables and write back to the RAMs. No
// new command is taken while one is in its execute cycle. Entry and link RAMs
// start undefined; no clearing pass is needed, since data read from an entry
// that was never written are never relied on.
// The active_nodes register is written through the cfg transaction channel
// only while no command is being taken or executed and no result is on the
// ports; node numbers at or above it report an invalid node.

module per_node_fcfs_queue_manager_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic [pnq_pkg::CMD_W-1:0]  command,
    input  wire logic [pnq_pkg::NODE_W-1:0] node_id,
    input  wire logic [pnq_pkg::TRAV_W-1:0] traveler,
    input  wire logic [pnq_pkg::PROC_W-1:0] process_id,
    input  wire logic [pnq_pkg::NODE_W-1:0] dest_node,
    input  wire logic                       cfg_valid,
    output      logic                       cfg_ready,
    input  wire logic [pnq_pkg::CFG_W-1:0]  cfg_data,
    output      logic                       result_valid,
    output      logic [pnq_pkg::STAT_W-1:0] status,
    output      logic [pnq_pkg::NODE_W-1:0] served_node,
    output      logic [pnq_pkg::TRAV_W-1:0] out_traveler,
    output      logic [pnq_pkg::PROC_W-1:0] out_process,
    output      logic [pnq_pkg::NODE_W-1:0] out_next_node,
    output      logic [pnq_pkg::STAMP_W-1:0] arrival_number,
    output      logic [pnq_pkg::CNT_W-1:0]  queue_length,
    output      logic                       has_waiting
);

    logic [pnq_pkg::CFG_W-1:0] active_nodes_reg;
    logic [pnq_pkg::CFG_W-1:0] node_limit;

    pnq_pkg::entry_req_t         entry_req;
    pnq_pkg::link_req_t          link_req;
    logic [pnq_pkg::ENTRY_W-1:0] entry_rdata;
    logic [pnq_pkg::PTR_W-1:0]   link_rdata;
    pnq_pkg::result_t            result;

    // The register only changes while no command is in flight: not while one
    // is taken or executed, and not while its result is still on the ports.
    assign cfg_ready = !busy && !start && !result_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_nodes_reg <= pnq_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_nodes_reg <= cfg_data;
        end
    end

    // Values beyond the number of built queues are clamped to it.
    assign node_limit = (active_nodes_reg > pnq_pkg::NODE_CAP) ? pnq_pkg::NODE_CAP
                                                              : active_nodes_reg;

    // Entry RAM holds the payload and arrival stamp of each pool entry.
    pnq_ram #(
        .WIDTH (pnq_pkg::ENTRY_W),
        .DEPTH (pnq_pkg::POOL_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_req.we),
        .waddr (entry_req.waddr),
        .wdata (entry_req.wdata),
        .re    (entry_req.re),
        .raddr (entry_req.raddr),
        .rdata (entry_rdata)
    );

    // Link RAM chains entries within a queue and along the free list; the
    // extra bit carries the end-of-list marker.
    pnq_ram #(
        .WIDTH (pnq_pkg::PTR_W),
        .DEPTH (pnq_pkg::POOL_ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .re    (link_req.re),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    pnq_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .node_id      (node_id),
        .traveler     (traveler),
        .process_id   (process_id),
        .dest_node    (dest_node),
        .node_limit   (node_limit),
        .busy         (busy),
        .entry_req    (entry_req),
        .entry_rdata  (entry_rdata),
        .link_req     (link_req),
        .link_rdata   (link_rdata),
        .result_valid (result_valid),
        .result       (result)
    );

    assign status         = result.status;
    assign served_node    = result.served_node;
    assign out_traveler   = result.out_traveler;
    assign out_process    = result.out_process;
    assign out_next_node  = result.out_next_node;
    assign arrival_number = result.arrival_number;
    assign queue_length   = result.queue_length;
    assign has_waiting    = result.has_waiting;

endmodule

`default_nettype wire

/* hw/rtl/pnq_checker.sv */
// Port-level checker for the queue manager, bound to the top level.
// Depends on pnq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnq_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        result_valid,
    input wire logic [pnq_pkg::STAT_W-1:0]  status,
    input wire logic [pnq_pkg::STAMP_W-1:0] arrival_number,
    input wire logic [pnq_pkg::CNT_W-1:0]   queue_length,
    input wire logic                        has_waiting
);

    // Every accepted command yields its result once its execute state has passed.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("accepted command produced no result");

    // No result without a matching accepted command.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without a matching command");

    // The block is busy in the cycle after it accepts a command.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // The waiting flag always agrees with the reported length.
    a_waiting_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (has_waiting == (queue_length != '0)))
        else $error("has_waiting disagrees with queue_length");

    // An invalid-node result carries no arrival number and a zero length.
    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == pnq_pkg::STAT_INVALID)
            |-> (arrival_number == '0 && queue_length == '0))
        else $error("invalid-node result carries data");

endmodule

bind per_node_fcfs_queue_manager_top pnq_checker u_pnq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_valid   (result_valid),
    .status         (status),
    .arrival_number (arrival_number),
    .queue_length   (queue_length),
    .has_waiting    (has_waiting)
);

`default_nettype wire
